// ===== sv/gncsp_pkg.sv =====
// Shared types and constants of the grid node cost shortest path unit.
package gncsp_pkg;

   localparam int MAX_WIDTH_DEF   = 64;
   localparam int MAX_HEIGHT_DEF  = 64;
   localparam int GRID_DIM_RESET  = 45;
   localparam int SPEED_W         = 16;
   localparam int DIST_W          = 32;
   localparam int COST_W          = 25;
   localparam int DIM_FIELD_W     = 7;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         cell_x;
      logic [5:0]         cell_y;
      logic [SPEED_W-1:0] speed;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              reachable;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_SEED,
      ST_POP,
      ST_POP_WAIT,
      ST_SD_RD,
      ST_SD_CMP,
      ST_SD_END,
      ST_NB,
      ST_NB_WAIT,
      ST_DIV,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_UP_END,
      ST_DONE
   } state_type;

endpackage

// ===== sv/gncsp_recip.sv =====
// Bit-serial reciprocal unit: quotient of 2^24 by a 16-bit speed, one bit per cycle.
module gncsp_recip (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [gncsp_pkg::SPEED_W-1:0]    divisor,
   output logic                             done,
   output logic [gncsp_pkg::COST_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [4:0]                        cnt_ff, cnt_in;
   logic [gncsp_pkg::SPEED_W:0]       rem_ff, rem_in;
   logic [gncsp_pkg::COST_W-1:0]      quo_ff, quo_in;
   logic [gncsp_pkg::SPEED_W-1:0]     div_ff, div_in;
   logic [gncsp_pkg::SPEED_W:0]       shifted;
   logic [gncsp_pkg::SPEED_W:0]       div_ext;

   // The dividend is a single one at bit 24, so the shifted-in bit is set only on the first step.
   always_comb begin
      div_ext = {1'b0, div_ff};
      shifted = {rem_ff[gncsp_pkg::SPEED_W-1:0], (cnt_ff == 5'd24)};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 5'd24;
         rem_in  = '0;
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= div_ext) begin
            rem_in = shifted - div_ext;
            quo_in = {quo_ff[gncsp_pkg::COST_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[gncsp_pkg::COST_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/grid_node_cost_shortest_path_unit.sv =====
// Top level of the grid node cost shortest path unit: sequencer, grid memories and binary heap.
// A load beat gives its result in the cycle after acceptance, a read beat after ST_RD_WAIT.
// A run beat first sweeps the reached flags of all MAX_WIDTH*MAX_HEIGHT cells, one cell a cycle,
// then pops each reached cell from the heap and pushes its open neighbours, using the bit-serial
// reciprocal and the single heap memory; busy stays high throughout.
// After reset the same flag sweep runs before the first beat is taken; results cannot be stalled.
module grid_node_cost_shortest_path_unit #(
   parameter int MAX_WIDTH  = gncsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gncsp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  gncsp_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   output gncsp_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gncsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gncsp_pkg::DIM_FIELD_W-1:0]      csr_data
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(CELLS);
   localparam int CW     = $clog2(CELLS + 1);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int GW     = $clog2(MAX_WIDTH + 1);
   localparam int GH     = $clog2(MAX_HEIGHT + 1);
   localparam int DW     = gncsp_pkg::DIST_W;
   localparam int SW     = gncsp_pkg::SPEED_W;
   localparam int HEW    = DW + YW + XW;
   localparam int GW_RST = (gncsp_pkg::GRID_DIM_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : gncsp_pkg::GRID_DIM_RESET;
   localparam int GH_RST = (gncsp_pkg::GRID_DIM_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : gncsp_pkg::GRID_DIM_RESET;

   // Grid storage. The distance memory carries the reached flag in its top bit.
   logic [SW-1:0]  spd_mem [CELLS];
   logic [DW:0]    dst_mem [CELLS];
   logic [HEW-1:0] hp_mem  [CELLS];

   gncsp_pkg::state_type state_ff, state_in;

   logic [GW-1:0]  gw_ff, gw_in;
   logic [GH-1:0]  gh_ff, gh_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           run_ff, run_in;
   logic           start_ok_ff, start_ok_in;
   logic [XW-1:0]  sx_ff, sx_in;
   logic [YW-1:0]  sy_ff, sy_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]  hi_ff, hi_in;
   logic [DW-1:0]  cur_d_ff, cur_d_in;
   logic [XW-1:0]  cur_x_ff, cur_x_in;
   logic [YW-1:0]  cur_y_ff, cur_y_in;
   logic [HEW-1:0] last_ff, last_in;
   logic [1:0]     nb_ff, nb_in;
   logic [DW-1:0]  nd_ff, nd_in;
   logic           rd_ok_ff, rd_ok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   gncsp_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0]  spd_rd_ff;
   logic [DW:0]    dst_rd_ff;
   logic [HEW-1:0] hpa_rd_ff, hpb_rd_ff;

   logic           spd_we;
   logic [AW-1:0]  spd_wa, spd_ra;
   logic           dst_we;
   logic [AW-1:0]  dst_wa, dst_ra;
   logic [DW:0]    dst_wd;
   logic           hp_we;
   logic [AW-1:0]  hp_wa, hp_ra, hp_rb;
   logic [HEW-1:0] hp_wd;

   logic                            recip_go;
   logic                            recip_done;
   logic [gncsp_pkg::COST_W-1:0]    recip_q;

   // Decoded request and neighbour of the cell being expanded.
   logic           accept;
   logic           req_inside;
   logic [AW-1:0]  req_addr;
   logic           nb_ok;
   logic [XW-1:0]  nbx;
   logic [YW-1:0]  nby;
   logic [AW-1:0]  nb_addr;
   logic           nb_last;
   logic           nb_open;
   logic [AW:0]    child_c;
   logic [AW+1:0]  cnt_wide;
   logic           child_in_heap;
   logic           right_in_heap;
   logic           pick_right;
   logic [HEW-1:0] child_ent;
   logic [AW-1:0]  parent_i;
   logic [DW:0]    nd_sum;
   logic           clr_last;

   assign accept     = start && (state_ff == gncsp_pkg::ST_IDLE);
   assign req_inside = (32'(req_data.cell_x) < 32'(MAX_WIDTH)) &&
                       (32'(req_data.cell_y) < 32'(MAX_HEIGHT));
   assign req_addr   = AW'(YW'(req_data.cell_y)) * AW'(MAX_WIDTH) +
                       AW'(XW'(req_data.cell_x));
   assign clr_last   = (clr_ff == AW'(CELLS - 1));

   // The neighbours are visited in the order left, right, up, down.
   always_comb begin
      nbx   = cur_x_ff;
      nby   = cur_y_ff;
      nb_ok = 1'b0;
      case (nb_ff)
         2'd0: begin
            nb_ok = (cur_x_ff != '0);
            nbx   = cur_x_ff - XW'(1);
         end
         2'd1: begin
            nb_ok = (10'(cur_x_ff) + 10'd1) < 10'(gw_ff);
            nbx   = cur_x_ff + XW'(1);
         end
         2'd2: begin
            nb_ok = (cur_y_ff != '0);
            nby   = cur_y_ff - YW'(1);
         end
         default: begin
            nb_ok = (10'(cur_y_ff) + 10'd1) < 10'(gh_ff);
            nby   = cur_y_ff + YW'(1);
         end
      endcase
   end

   assign nb_addr  = AW'(nby) * AW'(MAX_WIDTH) + AW'(nbx);
   assign nb_last  = (nb_ff == 2'd3);
   assign nb_open  = (spd_rd_ff != '0) && !dst_rd_ff[DW];

   // Sift-down children of heap slot hi and sift-up parent.
   assign child_c       = {hi_ff, 1'b1};
   assign cnt_wide      = (AW+2)'(cnt_ff);
   assign child_in_heap = ((AW+2)'(child_c) < cnt_wide);
   assign right_in_heap = ((AW+2)'(child_c) + (AW+2)'(1) < cnt_wide);
   assign pick_right    = right_in_heap &&
                          (hpb_rd_ff[HEW-1 -: DW] < hpa_rd_ff[HEW-1 -: DW]);
   assign child_ent     = pick_right ? hpb_rd_ff : hpa_rd_ff;
   assign parent_i      = (hi_ff - AW'(1)) >> 1;

   // Entry cost added to the expanded cell's distance, saturating.
   assign nd_sum = {1'b0, cur_d_ff} + (DW+1)'(recip_q);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gncsp_pkg::ST_CLEAR: begin
            if (clr_last) begin
               if (!run_ff) begin
                  state_in = gncsp_pkg::ST_IDLE;
               end else if (start_ok_ff) begin
                  state_in = gncsp_pkg::ST_SEED;
               end else begin
                  state_in = gncsp_pkg::ST_DONE;
               end
            end
         end
         gncsp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == gncsp_pkg::OP_RUN) begin
                  state_in = gncsp_pkg::ST_CLEAR;
               end else if (req_data.operation == gncsp_pkg::OP_READ) begin
                  state_in = gncsp_pkg::ST_RD_WAIT;
               end
            end
         end
         gncsp_pkg::ST_RD_WAIT: state_in = gncsp_pkg::ST_IDLE;
         gncsp_pkg::ST_SEED:    state_in = gncsp_pkg::ST_POP;
         gncsp_pkg::ST_POP:     state_in = gncsp_pkg::ST_POP_WAIT;
         gncsp_pkg::ST_POP_WAIT: begin
            state_in = (cnt_ff == CW'(1)) ? gncsp_pkg::ST_NB : gncsp_pkg::ST_SD_RD;
         end
         gncsp_pkg::ST_SD_RD: begin
            state_in = child_in_heap ? gncsp_pkg::ST_SD_CMP : gncsp_pkg::ST_SD_END;
         end
         gncsp_pkg::ST_SD_CMP: begin
            if (child_ent[HEW-1 -: DW] < last_ff[HEW-1 -: DW]) begin
               state_in = gncsp_pkg::ST_SD_RD;
            end else begin
               state_in = gncsp_pkg::ST_SD_END;
            end
         end
         gncsp_pkg::ST_SD_END: state_in = gncsp_pkg::ST_NB;
         gncsp_pkg::ST_NB: begin
            if (nb_ok) begin
               state_in = gncsp_pkg::ST_NB_WAIT;
            end else if (nb_last) begin
               state_in = (cnt_ff == '0) ? gncsp_pkg::ST_DONE : gncsp_pkg::ST_POP;
            end else begin
               state_in = gncsp_pkg::ST_NB;
            end
         end
         gncsp_pkg::ST_NB_WAIT: begin
            if (nb_open) begin
               state_in = gncsp_pkg::ST_DIV;
            end else if (nb_last) begin
               state_in = (cnt_ff == '0) ? gncsp_pkg::ST_DONE : gncsp_pkg::ST_POP;
            end else begin
               state_in = gncsp_pkg::ST_NB;
            end
         end
         gncsp_pkg::ST_DIV: begin
            if (recip_done) begin
               state_in = gncsp_pkg::ST_UP_CHK;
            end
         end
         gncsp_pkg::ST_UP_CHK: begin
            state_in = (hi_ff == '0) ? gncsp_pkg::ST_UP_END : gncsp_pkg::ST_UP_CMP;
         end
         gncsp_pkg::ST_UP_CMP: begin
            if (hpa_rd_ff[HEW-1 -: DW] <= nd_ff) begin
               state_in = gncsp_pkg::ST_UP_END;
            end else begin
               state_in = gncsp_pkg::ST_UP_CHK;
            end
         end
         gncsp_pkg::ST_UP_END: begin
            if (nb_last) begin
               state_in = (cnt_ff == '0) ? gncsp_pkg::ST_DONE : gncsp_pkg::ST_POP;
            end else begin
               state_in = gncsp_pkg::ST_NB;
            end
         end
         gncsp_pkg::ST_DONE: state_in = gncsp_pkg::ST_IDLE;
         default:            state_in = gncsp_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and results.
   always_comb begin
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      clr_in       = clr_ff;
      run_in       = run_ff;
      start_ok_in  = start_ok_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      cnt_in       = cnt_ff;
      hi_in        = hi_ff;
      cur_d_in     = cur_d_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      last_in      = last_ff;
      nb_in        = nb_ff;
      nd_in        = nd_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      spd_we       = 1'b0;
      spd_wa       = req_addr;
      spd_ra       = nb_addr;
      dst_we       = 1'b0;
      dst_wa       = nb_addr;
      dst_wd       = {1'b1, nd_sum[DW] ? {DW{1'b1}} : nd_sum[DW-1:0]};
      dst_ra       = nb_addr;
      hp_we        = 1'b0;
      hp_wa        = hi_ff;
      hp_wd        = last_ff;
      hp_ra        = AW'(child_c);
      hp_rb        = AW'((AW+1)'(child_c) + (AW+1)'(1));
      recip_go     = 1'b0;

      // Register writes clamp zero to one and large values to the storage size.
      if (csr_valid) begin
         if (csr_index == gncsp_pkg::CSR_GRID_WIDTH) begin
            if (csr_data == '0) begin
               gw_in = GW'(1);
            end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
               gw_in = GW'(MAX_WIDTH);
            end else begin
               gw_in = GW'(csr_data);
            end
         end else if (csr_index == gncsp_pkg::CSR_GRID_HEIGHT) begin
            if (csr_data == '0) begin
               gh_in = GH'(1);
            end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
               gh_in = GH'(MAX_HEIGHT);
            end else begin
               gh_in = GH'(csr_data);
            end
         end
      end

      case (state_ff)
         gncsp_pkg::ST_CLEAR: begin
            dst_we = 1'b1;
            dst_wa = clr_ff;
            dst_wd = '0;
            clr_in = clr_last ? '0 : clr_ff + AW'(1);
            if (clr_last && !run_ff) begin
               run_in = 1'b0;
            end
         end
         gncsp_pkg::ST_IDLE: begin
            dst_ra = req_addr;
            if (accept) begin
               rd_ok_in = req_inside;
               if (req_data.operation == gncsp_pkg::OP_RUN) begin
                  run_in      = 1'b1;
                  clr_in      = '0;
                  sx_in       = XW'(req_data.cell_x);
                  sy_in       = YW'(req_data.cell_y);
                  start_ok_in = (32'(req_data.cell_x) < 32'(gw_ff)) &&
                                (32'(req_data.cell_y) < 32'(gh_ff));
               end else if (req_data.operation != gncsp_pkg::OP_READ) begin
                  spd_we       = (req_data.operation == gncsp_pkg::OP_LOAD) && req_inside;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         gncsp_pkg::ST_RD_WAIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.reachable   = rd_ok_ff && dst_rd_ff[DW];
            rsp_in.distance    = (rd_ok_ff && dst_rd_ff[DW]) ? dst_rd_ff[DW-1:0] : '0;
         end
         gncsp_pkg::ST_SEED: begin
            dst_we = 1'b1;
            dst_wa = AW'(sy_ff) * AW'(MAX_WIDTH) + AW'(sx_ff);
            dst_wd = {1'b1, {DW{1'b0}}};
            hp_we  = 1'b1;
            hp_wa  = '0;
            hp_wd  = {{DW{1'b0}}, sy_ff, sx_ff};
            cnt_in = CW'(1);
         end
         gncsp_pkg::ST_POP: begin
            hp_ra = '0;
            hp_rb = AW'(cnt_ff - CW'(1));
         end
         gncsp_pkg::ST_POP_WAIT: begin
            cur_d_in = hpa_rd_ff[HEW-1 -: DW];
            cur_y_in = hpa_rd_ff[XW +: YW];
            cur_x_in = hpa_rd_ff[XW-1:0];
            last_in  = hpb_rd_ff;
            cnt_in   = cnt_ff - CW'(1);
            hi_in    = '0;
            nb_in    = 2'd0;
         end
         gncsp_pkg::ST_SD_CMP: begin
            if (child_ent[HEW-1 -: DW] < last_ff[HEW-1 -: DW]) begin
               hp_we = 1'b1;
               hp_wd = child_ent;
               hi_in = pick_right ? AW'((AW+1)'(child_c) + (AW+1)'(1)) : AW'(child_c);
            end
         end
         gncsp_pkg::ST_SD_END: begin
            hp_we = 1'b1;
            hp_wd = last_ff;
            nb_in = 2'd0;
         end
         gncsp_pkg::ST_NB: begin
            if (!nb_ok) begin
               nb_in = nb_ff + 2'd1;
            end
         end
         gncsp_pkg::ST_NB_WAIT: begin
            if (nb_open) begin
               recip_go = 1'b1;
            end else begin
               nb_in = nb_ff + 2'd1;
            end
         end
         gncsp_pkg::ST_DIV: begin
            if (recip_done) begin
               dst_we = 1'b1;
               nd_in  = nd_sum[DW] ? {DW{1'b1}} : nd_sum[DW-1:0];
               hi_in  = AW'(cnt_ff);
               cnt_in = cnt_ff + CW'(1);
            end
         end
         gncsp_pkg::ST_UP_CHK: begin
            hp_ra = parent_i;
         end
         gncsp_pkg::ST_UP_CMP: begin
            if (!(hpa_rd_ff[HEW-1 -: DW] <= nd_ff)) begin
               hp_we = 1'b1;
               hp_wd = hpa_rd_ff;
               hi_in = parent_i;
            end
         end
         gncsp_pkg::ST_UP_END: begin
            hp_we = 1'b1;
            hp_wd = {nd_ff, nby, nbx};
            nb_in = nb_ff + 2'd1;
         end
         gncsp_pkg::ST_DONE: begin
            run_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
         end
         default: begin
         end
      endcase
   end

   gncsp_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .go       (recip_go),
      .divisor  (spd_rd_ff),
      .done     (recip_done),
      .quotient (recip_q)
   );

   always_ff @(posedge clock) begin
      if (spd_we) begin
         spd_mem[spd_wa] <= req_data.speed;
      end
      spd_rd_ff <= spd_mem[spd_ra];
   end

   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_wa] <= dst_wd;
      end
      dst_rd_ff <= dst_mem[dst_ra];
   end

   always_ff @(posedge clock) begin
      if (hp_we) begin
         hp_mem[hp_wa] <= hp_wd;
      end
      hpa_rd_ff <= hp_mem[hp_ra];
      hpb_rd_ff <= hp_mem[hp_rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gncsp_pkg::ST_CLEAR;
         gw_ff        <= GW'(GW_RST);
         gh_ff        <= GH'(GH_RST);
         clr_ff       <= '0;
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         nb_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         clr_ff       <= clr_in;
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ok_ff <= start_ok_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      hi_ff       <= hi_in;
      cur_d_ff    <= cur_d_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      last_ff     <= last_in;
      nd_ff       <= nd_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != gncsp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
